// File: rtl/core/source_lexer_core_macros.svh
// Assertion macros shared by the lexer core modules.
`ifndef SOURCE_LEXER_CORE_MACROS_SVH
`define SOURCE_LEXER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SLX_ASSERT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("lexer core assertion failed");
`define SLX_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("lexer core assertion failed");
`else
`define SLX_ASSERT(label, clk, rst_n, pre, post)
`define SLX_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// File: rtl/core/slx_pkg.sv
`timescale 1ns / 1ps
package slx_pkg;

	localparam int DEF_POSITION_BITS = 32;
	localparam int DEF_LENGTH_BITS = 16;
	localparam int DEF_WORD_BUFFER_CHARS = 6;
	localparam int DEF_QUEUE_DEPTH = 4;

	typedef logic [2:0] kind_t;
	localparam kind_t KIND_KEYWORD = 3'd0;
	localparam kind_t KIND_IDENT = 3'd1;
	localparam kind_t KIND_NUMBER = 3'd2;
	localparam kind_t KIND_OPER = 3'd3;
	localparam kind_t KIND_SEPAR = 3'd4;
	localparam kind_t KIND_LITERAL = 3'd5;
	localparam kind_t KIND_UNKNOWN = 3'd6;

	typedef logic [3:0] word_idx_t;
	localparam word_idx_t WORD_NONE = 4'd9;

	localparam int NUM_WORDS = 9;
	localparam int KEYWORD_COUNT = 7;
	localparam int WORD_MAX = 6;

	localparam logic [7:0] WORD_TEXT [NUM_WORDS][WORD_MAX] = '{
		'{"i", "n", "t", 8'h00, 8'h00, 8'h00},
		'{"f", "l", "o", "a", "t", 8'h00},
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"e", "l", "s", "e", 8'h00, 8'h00},
		'{"w", "h", "i", "l", "e", 8'h00},
		'{"f", "o", "r", 8'h00, 8'h00, 8'h00},
		'{"r", "e", "t", "u", "r", "n"},
		'{"t", "r", "u", "e", 8'h00, 8'h00},
		'{"f", "a", "l", "s", "e", 8'h00}
	};
	localparam int WORD_LEN [NUM_WORDS] = '{3, 5, 2, 4, 5, 3, 6, 4, 5};

	typedef struct packed {
		logic [7:0] source_byte;
		logic end_of_source;
	} in_item_t;

	typedef struct packed {
		kind_t token_kind;
		logic [31:0] start_position;
		logic [15:0] token_length;
		word_idx_t word_index;
	} token_t;

	typedef struct packed {
		kind_t token_kind;
		logic [31:0] start_position;
		logic [15:0] token_length;
		word_idx_t word_index;
		logic last_of_run;
	} out_item_t;

	typedef struct packed {
		logic two;
		token_t first;
		token_t second;
	} entry_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c inside {["a":"z"], ["A":"Z"]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c inside {["0":"9"]});
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c inside {" ", [8'd9:8'd13]});
	endfunction

	function automatic logic is_pair_first(input logic [7:0] c);
		return (c inside {"=", "!", "<", ">", "&", "|"});
	endfunction

	function automatic logic is_arith(input logic [7:0] c);
		return (c inside {"+", "-", "*", "/"});
	endfunction

	function automatic logic is_separ(input logic [7:0] c);
		return (c inside {";", ",", "(", ")", "{", "}"});
	endfunction

	function automatic logic is_quote(input logic [7:0] c);
		return (c inside {"\"", "'"});
	endfunction

	function automatic token_t make_token(input kind_t k, input logic [31:0] s,
			input logic [15:0] n);
		token_t t;
		t.token_kind = k;
		t.start_position = s;
		t.token_length = n;
		t.word_index = WORD_NONE;
		return t;
	endfunction

endpackage

// File: rtl/core/slx_in_if.sv
`timescale 1ns / 1ps
interface slx_in_if import slx_pkg::*; ();
	logic valid;
	logic ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/core/slx_out_if.sv
`timescale 1ns / 1ps
interface slx_out_if import slx_pkg::*; ();
	logic valid;
	logic ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/core/source_lexer_core.sv
// A token is pushed into the queue with its closing byte, then loaded into the output register.
// Throughput: one byte per cycle unless the queue is full; two tokens of one byte go out in turn.
// Output: one token per cycle while tokens.ready is high, from a queue of QUEUE_DEPTH byte results.
// Reset: arst_n clears the scan mode, the byte position, the queue and the output valid flag.
`timescale 1ns / 1ps
module source_lexer_core import slx_pkg::*; #(
	parameter int POSITION_BITS = DEF_POSITION_BITS,
	parameter int LENGTH_BITS = DEF_LENGTH_BITS,
	parameter int WORD_BUFFER_CHARS = DEF_WORD_BUFFER_CHARS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	slx_in_if.sink bytes,
	slx_out_if.source tokens
);

	logic push;
	logic full;
	logic pop;
	logic avail;
	entry_t push_entry;
	entry_t head;

	slx_front #(
		.POSITION_BITS(POSITION_BITS),
		.LENGTH_BITS(LENGTH_BITS),
		.WORD_BUFFER_CHARS(WORD_BUFFER_CHARS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(bytes),
		.full(full),
		.push(push),
		.push_entry(push_entry)
	);

	slx_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.full(full),
		.pop(pop),
		.avail(avail),
		.head(head)
	);

	slx_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.avail(avail),
		.head(head),
		.pop(pop),
		.tokens(tokens)
	);

endmodule

// File: rtl/core/slx_front.sv
`timescale 1ns / 1ps
`include "source_lexer_core_macros.svh"
module slx_front import slx_pkg::*; #(
	parameter int POSITION_BITS = DEF_POSITION_BITS,
	parameter int LENGTH_BITS = DEF_LENGTH_BITS,
	parameter int WORD_BUFFER_CHARS = DEF_WORD_BUFFER_CHARS
) (
	input logic clk,
	input logic arst_n,
	slx_in_if.sink bytes,
	input logic full,
	output logic push,
	output entry_t push_entry
);

	localparam int IDX_W = $clog2(WORD_BUFFER_CHARS);

	localparam logic [2:0] MODE_IDLE = 3'd0;
	localparam logic [2:0] MODE_WORD = 3'd1;
	localparam logic [2:0] MODE_NUMBER = 3'd2;
	localparam logic [2:0] MODE_OPER = 3'd3;
	localparam logic [2:0] MODE_STRING = 3'd4;
	localparam logic [2:0] MODE_ESC = 3'd5;

	logic [2:0] mode_q, mode_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d;
	logic [POSITION_BITS-1:0] start_q, start_d;
	logic [LENGTH_BITS-1:0] count_q, count_d, count_inc;
	logic [WORD_BUFFER_CHARS-1:0][7:0] wbuf_q, wbuf_d;
	logic [7:0] pend_q, pend_d;
	logic [7:0] quote_q, quote_d;
	logic [7:0] c;
	logic last;
	logic acc;
	logic fresh;
	logic tk_v, fr_v, fl_v;
	token_t tk, fr, fl;

	function automatic token_t word_token(input logic [WORD_BUFFER_CHARS-1:0][7:0] b,
			input logic [LENGTH_BITS-1:0] n, input logic [POSITION_BITS-1:0] s);
		token_t t;
		logic hit;
		logic same;
		t = make_token(KIND_IDENT, 32'(s), 16'(n));
		hit = 1'b0;
		for (int i = 0; i < NUM_WORDS; i++) begin
			same = (32'(n) == 32'(WORD_LEN[i]));
			for (int j = 0; j < WORD_MAX; j++) begin
				if (j < WORD_LEN[i] && b[j] != WORD_TEXT[i][j]) begin
					same = 1'b0;
				end
			end
			if (same && !hit) begin
				hit = 1'b1;
				t.token_kind = (i < KEYWORD_COUNT) ? KIND_KEYWORD : KIND_LITERAL;
				t.word_index = 4'(i);
			end
		end
		return t;
	endfunction

	function automatic token_t single_op(input logic [7:0] p, input logic [POSITION_BITS-1:0] s);
		return make_token((p == "&" || p == "|") ? KIND_UNKNOWN : KIND_OPER, 32'(s), 16'd1);
	endfunction

	assign c = bytes.data.source_byte;
	assign last = bytes.data.end_of_source;
	assign bytes.ready = !full;
	assign acc = bytes.valid && !full;
	assign count_inc = (&count_q) ? count_q : count_q + LENGTH_BITS'(1);

	always_comb begin
		mode_d = mode_q;
		start_d = start_q;
		count_d = count_q;
		wbuf_d = wbuf_q;
		pend_d = pend_q;
		quote_d = quote_q;
		fresh = 1'b0;
		tk_v = 1'b0;
		fr_v = 1'b0;
		fl_v = 1'b0;
		tk = '0;
		fr = '0;
		fl = '0;

		case (mode_q)
			MODE_WORD: begin
				if (is_alpha(c) || is_digit(c) || c == "_") begin
					if (32'(count_q) < 32'(WORD_BUFFER_CHARS)) begin
						wbuf_d[count_q[IDX_W-1:0]] = c;
					end
					count_d = count_inc;
				end else begin
					tk_v = 1'b1;
					tk = word_token(wbuf_q, count_q, start_q);
					fresh = 1'b1;
				end
			end
			MODE_NUMBER: begin
				if (is_digit(c)) begin
					count_d = count_inc;
				end else begin
					tk_v = 1'b1;
					tk = make_token(KIND_NUMBER, 32'(start_q), 16'(count_q));
					fresh = 1'b1;
				end
			end
			MODE_OPER: begin
				tk_v = 1'b1;
				if ((c == "=" && (pend_q inside {"=", "!", "<", ">"})) ||
						(c == "&" && pend_q == "&") || (c == "|" && pend_q == "|")) begin
					tk = make_token(KIND_OPER, 32'(start_q), 16'd2);
					mode_d = MODE_IDLE;
				end else begin
					tk = single_op(pend_q, start_q);
					fresh = 1'b1;
				end
			end
			MODE_STRING: begin
				if (c == quote_q) begin
					tk_v = 1'b1;
					tk = make_token(KIND_LITERAL, 32'(start_q), 16'(count_q));
					mode_d = MODE_IDLE;
				end else begin
					if (c == "\\") begin
						mode_d = MODE_ESC;
					end
					count_d = count_inc;
				end
			end
			MODE_ESC: begin
				count_d = count_inc;
				mode_d = MODE_STRING;
			end
			default: begin
				fresh = 1'b1;
			end
		endcase

		if (fresh) begin
			mode_d = MODE_IDLE;
			if (!is_space(c)) begin
				if (is_alpha(c) || c == "_") begin
					mode_d = MODE_WORD;
					start_d = pos_q;
					count_d = LENGTH_BITS'(1);
					wbuf_d[0] = c;
				end else if (is_digit(c)) begin
					mode_d = MODE_NUMBER;
					start_d = pos_q;
					count_d = LENGTH_BITS'(1);
				end else if (is_pair_first(c)) begin
					mode_d = MODE_OPER;
					pend_d = c;
					start_d = pos_q;
				end else if (is_arith(c)) begin
					fr_v = 1'b1;
					fr = make_token(KIND_OPER, 32'(pos_q), 16'd1);
				end else if (is_separ(c)) begin
					fr_v = 1'b1;
					fr = make_token(KIND_SEPAR, 32'(pos_q), 16'd1);
				end else if (is_quote(c)) begin
					mode_d = MODE_STRING;
					quote_d = c;
					start_d = pos_q + POSITION_BITS'(1);
					count_d = '0;
				end else begin
					fr_v = 1'b1;
					fr = make_token(KIND_UNKNOWN, 32'(pos_q), 16'd1);
				end
			end
		end

		if (last) begin
			case (mode_d)
				MODE_WORD: begin
					fl_v = 1'b1;
					fl = word_token(wbuf_d, count_d, start_d);
				end
				MODE_NUMBER: begin
					fl_v = 1'b1;
					fl = make_token(KIND_NUMBER, 32'(start_d), 16'(count_d));
				end
				MODE_OPER: begin
					fl_v = 1'b1;
					fl = single_op(pend_d, start_d);
				end
				MODE_STRING, MODE_ESC: begin
					fl_v = 1'b1;
					fl = make_token(KIND_LITERAL, 32'(start_d), 16'(count_d));
				end
				default: begin
					fl_v = 1'b0;
				end
			endcase
			mode_d = MODE_IDLE;
		end
	end

	assign pos_d = last ? '0 : pos_q + POSITION_BITS'(1);

	assign push = acc && (tk_v || fr_v || fl_v);
	assign push_entry.two = tk_v && (fr_v || fl_v);
	assign push_entry.first = tk_v ? tk : (fr_v ? fr : fl);
	assign push_entry.second = (tk_v && fr_v) ? fr : fl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pos_q <= '0;
		end else if (acc) begin
			mode_q <= mode_d;
			pos_q <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			start_q <= start_d;
			count_q <= count_d;
			wbuf_q <= wbuf_d;
			pend_q <= pend_d;
			quote_q <= quote_d;
		end
	end

	`SLX_ASSERT_NEXT(end_returns_idle, clk, arst_n, acc && last, mode_q == MODE_IDLE && pos_q == '0)
	`SLX_ASSERT_NEXT(escape_resumes_string, clk, arst_n, acc && mode_q == MODE_ESC && !last, mode_q == MODE_STRING)

endmodule

// File: rtl/core/slx_queue.sv
`timescale 1ns / 1ps
`include "source_lexer_core_macros.svh"
module slx_queue import slx_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input entry_t push_entry,
	output logic full,
	input logic pop,
	output logic avail,
	output entry_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	function automatic logic [AW-1:0] advance(input logic [AW-1:0] p);
		return (32'(p) == DEPTH - 1) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= advance(wr_q);
			end
			if (pop) begin
				rd_q <= advance(rd_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	assign head = mem_q[rd_q];
	assign avail = (count_q != '0);
	assign full = (count_q == CW'(DEPTH));

	`SLX_ASSERT(no_overflow, clk, arst_n, push, !full)
	`SLX_ASSERT(no_underflow, clk, arst_n, pop, avail)

endmodule

// File: rtl/core/slx_back.sv
`timescale 1ns / 1ps
`include "source_lexer_core_macros.svh"
module slx_back import slx_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic avail,
	input entry_t head,
	output logic pop,
	slx_out_if.source tokens
);

	entry_t hold_q;
	logic valid_q;
	logic sel_q;
	logic last;
	logic done;
	token_t cur;

	assign cur = sel_q ? hold_q.second : hold_q.first;
	assign last = !hold_q.two || sel_q;
	assign done = valid_q && tokens.ready;
	assign pop = avail && (!valid_q || (done && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
			sel_q <= 1'b0;
		end else if (done) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				sel_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			hold_q <= head;
		end
	end

	assign tokens.valid = valid_q;
	assign tokens.data.token_kind = cur.token_kind;
	assign tokens.data.start_position = cur.start_position;
	assign tokens.data.token_length = cur.token_length;
	assign tokens.data.word_index = cur.word_index;
	assign tokens.data.last_of_run = last;

	`SLX_ASSERT(second_only_in_pair, clk, arst_n, valid_q && sel_q, hold_q.two)
	`SLX_ASSERT_NEXT(pair_moves_on, clk, arst_n, done && !last, valid_q && sel_q)

endmodule

// File: bench/source_lexer_core_test.sv
`timescale 1ns / 1ps
module source_lexer_core_test;
	import slx_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_BYTES = 180;
	localparam string LEAD_CHARS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
	localparam string IDENT_CHARS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_WORD,
		SCAN_NUMBER,
		SCAN_OPER,
		SCAN_STRING,
		SCAN_ESCAPE
	} scan_mode_t;

	class token_scoreboard;
		out_item_t expected_tokens[$];
		out_item_t step_out[$];
		int failures;
		scan_mode_t mode;
		logic [31:0] position;
		logic [31:0] tok_start;
		logic [15:0] tok_len;
		logic [7:0] word_chars [DEF_WORD_BUFFER_CHARS];
		logic [7:0] held_op;
		logic [7:0] quote_char;

		function new();
			failures = 0;
			mode = SCAN_IDLE;
			position = '0;
			tok_start = '0;
			tok_len = '0;
			held_op = '0;
			quote_char = '0;
			foreach (word_chars[i])
				word_chars[i] = 8'h00;
		endfunction

		function bit is_letter(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		endfunction

		function bit is_numeral(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
		endfunction

		function void add_token(kind_t kind, logic [31:0] start, logic [15:0] len,
				word_idx_t idx);
			out_item_t t;
			t.token_kind = kind;
			t.start_position = start;
			t.token_length = len;
			t.word_index = idx;
			t.last_of_run = 1'b0;
			step_out.insert(step_out.size(), t);
		endfunction

		function void bump_len();
			if (tok_len != 16'hFFFF)
				tok_len++;
		endfunction

		function void close_word();
			word_idx_t idx;
			bit same;
			idx = WORD_NONE;
			for (int i = 0; i < NUM_WORDS; i++) begin
				same = (tok_len == WORD_LEN[i]);
				for (int j = 0; j < WORD_LEN[i]; j++)
					if (word_chars[j] != WORD_TEXT[i][j])
						same = 1'b0;
				if (same)
					idx = word_idx_t'(i);
			end
			if (idx == WORD_NONE)
				add_token(KIND_IDENT, tok_start, tok_len, WORD_NONE);
			else
				add_token(idx < KEYWORD_COUNT ? KIND_KEYWORD : KIND_LITERAL,
					tok_start, tok_len, idx);
		endfunction

		function void close_op();
			add_token((held_op == "&" || held_op == "|") ? KIND_UNKNOWN : KIND_OPER,
				tok_start, 16'd1, WORD_NONE);
		endfunction

		function void open_token(logic [7:0] c, logic [31:0] here);
			if (is_blank(c))
				return;
			if (is_letter(c) || c == "_") begin
				mode = SCAN_WORD;
				tok_start = here;
				tok_len = 16'd1;
				word_chars[0] = c;
			end else if (is_numeral(c)) begin
				mode = SCAN_NUMBER;
				tok_start = here;
				tok_len = 16'd1;
			end else if (c inside {"=", "!", "<", ">", "&", "|"}) begin
				mode = SCAN_OPER;
				held_op = c;
				tok_start = here;
			end else if (c inside {"+", "-", "*", "/"}) begin
				add_token(KIND_OPER, here, 16'd1, WORD_NONE);
			end else if (c inside {";", ",", "(", ")", "{", "}"}) begin
				add_token(KIND_SEPAR, here, 16'd1, WORD_NONE);
			end else if (c == "\"" || c == "'") begin
				mode = SCAN_STRING;
				quote_char = c;
				tok_start = here + 32'd1;
				tok_len = 16'd0;
			end else begin
				add_token(KIND_UNKNOWN, here, 16'd1, WORD_NONE);
			end
		endfunction

		function void take(logic [7:0] c, logic [31:0] here);
			bit restart;
			restart = 1'b1;
			case (mode)
				SCAN_WORD: begin
					if (is_letter(c) || is_numeral(c) || c == "_") begin
						if (tok_len < DEF_WORD_BUFFER_CHARS)
							word_chars[3'(tok_len)] = c;
						bump_len();
						restart = 1'b0;
					end else begin
						close_word();
					end
				end
				SCAN_NUMBER: begin
					if (is_numeral(c)) begin
						bump_len();
						restart = 1'b0;
					end else begin
						add_token(KIND_NUMBER, tok_start, tok_len, WORD_NONE);
					end
				end
				SCAN_OPER: begin
					if ((c == "=" && held_op inside {"=", "!", "<", ">"}) ||
							(c == "&" && held_op == "&") || (c == "|" && held_op == "|")) begin
						add_token(KIND_OPER, tok_start, 16'd2, WORD_NONE);
						mode = SCAN_IDLE;
						restart = 1'b0;
					end else begin
						close_op();
					end
				end
				SCAN_STRING: begin
					restart = 1'b0;
					if (c == quote_char) begin
						add_token(KIND_LITERAL, tok_start, tok_len, WORD_NONE);
						mode = SCAN_IDLE;
					end else begin
						if (c == "\\")
							mode = SCAN_ESCAPE;
						bump_len();
					end
				end
				SCAN_ESCAPE: begin
					bump_len();
					mode = SCAN_STRING;
					restart = 1'b0;
				end
				default: begin
				end
			endcase
			if (restart) begin
				mode = SCAN_IDLE;
				open_token(c, here);
			end
		endfunction

		function void flush_pending();
			case (mode)
				SCAN_WORD: close_word();
				SCAN_NUMBER: add_token(KIND_NUMBER, tok_start, tok_len, WORD_NONE);
				SCAN_OPER: close_op();
				SCAN_STRING, SCAN_ESCAPE: add_token(KIND_LITERAL, tok_start, tok_len, WORD_NONE);
				default: begin
				end
			endcase
			mode = SCAN_IDLE;
		endfunction

		function void note_byte(in_item_t item);
			logic [31:0] here;
			out_item_t t;
			here = position;
			step_out.delete();
			take(item.source_byte, here);
			if (item.end_of_source) begin
				flush_pending();
				position = '0;
			end else begin
				position = here + 32'd1;
			end
			foreach (step_out[i]) begin
				t = step_out[i];
				t.last_of_run = (i == step_out.size() - 1);
				expected_tokens.insert(expected_tokens.size(), t);
			end
		endfunction

		function void report_field(string field, logic [31:0] want_v, logic [31:0] got_v);
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
			failures++;
		endfunction

		function void check_token(out_item_t got);
			out_item_t want;
			if (expected_tokens.size() == 0) begin
				$display("%0t: unexpected token, expected none, actual kind %0d start %0d length %0d",
					$time, got.token_kind, got.start_position, got.token_length);
				failures++;
				return;
			end
			want = expected_tokens.pop_front();
			if (got.token_kind !== want.token_kind)
				report_field("token_kind", 32'(want.token_kind), 32'(got.token_kind));
			if (got.start_position !== want.start_position)
				report_field("start_position", want.start_position, got.start_position);
			if (got.token_length !== want.token_length)
				report_field("token_length", 32'(want.token_length), 32'(got.token_length));
			if (got.word_index !== want.word_index)
				report_field("word_index", 32'(want.word_index), 32'(got.word_index));
			if (got.last_of_run !== want.last_of_run)
				report_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	slx_in_if byte_ch();
	slx_out_if token_ch();

	token_scoreboard board;
	in_item_t byte_stream[$];
	bit paced;
	int idle_cycles = 0;

	source_lexer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(byte_ch.sink),
		.tokens(token_ch.source)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void add_byte(logic [7:0] c, bit last);
		in_item_t item;
		item.source_byte = c;
		item.end_of_source = last;
		byte_stream.insert(byte_stream.size(), item);
	endfunction

	function automatic void add_text(string s, bit last);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i], last && i == s.len() - 1);
	endfunction

	function automatic logic [7:0] pick(string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	function automatic void add_random_token();
		int w;
		logic [7:0] q;
		case ($urandom_range(0, 9))
			0: begin
				w = $urandom_range(0, NUM_WORDS - 1);
				for (int j = 0; j < WORD_LEN[w]; j++)
					add_byte(WORD_TEXT[w][j], 1'b0);
				if ($urandom_range(0, 3) == 0)
					add_byte(pick(IDENT_CHARS), 1'b0);
			end
			1: begin
				add_byte(pick(LEAD_CHARS), 1'b0);
				repeat ($urandom_range(0, 8))
					add_byte(pick(IDENT_CHARS), 1'b0);
			end
			2: repeat ($urandom_range(1, 5))
				add_byte(pick("0123456789"), 1'b0);
			3: begin
				if ($urandom_range(0, 1) == 1) begin
					add_byte(pick("=!<>&|"), 1'b0);
					add_byte(pick("=&|"), 1'b0);
				end else begin
					add_byte(pick("+-*/=<>!&|"), 1'b0);
				end
			end
			4: add_byte(pick(";,(){}"), 1'b0);
			5: begin
				q = ($urandom_range(0, 1) == 1) ? "\"" : "'";
				add_byte(q, 1'b0);
				repeat ($urandom_range(0, 5)) begin
					if ($urandom_range(0, 3) == 0) begin
						add_byte("\\", 1'b0);
						add_byte(8'($urandom_range(0, 255)), 1'b0);
					end else begin
						add_byte(8'($urandom_range(32, 126)), 1'b0);
					end
				end
				if ($urandom_range(0, 7) != 0)
					add_byte(q, 1'b0);
			end
			6, 7: add_byte(($urandom_range(0, 1) == 1) ? 8'd32 : 8'($urandom_range(9, 13)), 1'b0);
			default: add_byte(8'($urandom_range(0, 255)), 1'b0);
		endcase
	endfunction

	function automatic void compose_source();
		repeat ($urandom_range(2, 10))
			add_random_token();
		if ($urandom_range(0, 1) == 1)
			add_byte(pick("a7=&'\" \\;"), 1'b1);
		else
			add_byte(8'($urandom_range(0, 255)), 1'b1);
	endfunction

	task automatic send_stream();
		in_item_t item;
		int gap;
		while (byte_stream.size() > 0) begin
			item = byte_stream.pop_front();
			gap = paced ? $urandom_range(0, 10) : 0;
			if (gap > 0) begin
				byte_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			byte_ch.valid <= 1'b1;
			byte_ch.data <= item;
			do @(posedge clk); while (byte_ch.ready !== 1'b1);
			board.note_byte(item);
		end
	endtask

	initial begin
		int sent;
		board = new();
		arst_n <= 1'b0;
		byte_ch.valid <= 1'b0;
		byte_ch.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		paced = 1'b1;
		add_text("int a>=9;&&'\\", 1'b1);
		add_text("\"\"|", 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h00, 1'b1);
		add_text("false&", 1'b1);
		add_text("\"ab", 1'b1);
		send_stream();

		sent = 0;
		while (sent < RANDOM_BYTES) begin
			compose_source();
			sent += byte_stream.size();
			paced = ($urandom_range(0, 3) != 0);
			send_stream();
		end
		byte_ch.valid <= 1'b0;

		while (board.expected_tokens.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (board.failures == 0 && board.expected_tokens.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int stall;
		int taken;
		taken = 0;
		token_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken == 30)
				stall = 150;
			else if (taken % 50 >= 40)
				stall = 0;
			else
				stall = $urandom_range(0, 10);
			if (stall > 0) begin
				token_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			token_ch.ready <= 1'b1;
			do @(posedge clk); while (token_ch.valid !== 1'b1);
			board.check_token(token_ch.data);
			taken++;
		end
	end

	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (token_ch.valid && token_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
